[hw/rtl/clws_pkg.sv]
package clws_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned ROW_W    = 2;
  localparam int unsigned NUMBER_W = 16;
  localparam int unsigned CFG_W    = 8;

  // Configuration register file
  localparam int unsigned NUM_REGS  = 6;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

  localparam logic [REG_IDX_W-1:0] REG_FUNCTION_SET = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_DISPLAY_ON   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CLEAR        = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_MODE   = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_CURSOR_RIGHT = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_SECOND_ROW   = REG_IDX_W'(5);

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    8'd56, 8'd15, 8'd1, 8'd6, 8'd20, 8'd192
  };

  // The init run walks the first registers of the file in order
  localparam int unsigned INIT_WRITES = 4;
  localparam int unsigned INIT_IDX_W  = $clog2(INIT_WRITES);

  // Geometry and number formatting
  localparam int unsigned COLUMNS_DEF = 40;
  localparam int unsigned NUM_DIGITS  = 5;
  localparam int unsigned DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
  localparam int unsigned DIG_IDX_W   = $clog2(NUM_DIGITS);
  localparam int unsigned DIGIT_W     = 4;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [NUMBER_W-1:0] DIV10_MUL   = 16'hCCCD;
  localparam int unsigned         DIV10_SHIFT = 19;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 3'd0,
    CMD_INSTR  = 3'd1,
    CMD_DATA   = 3'd2,
    CMD_GOTO   = 3'd3,
    CMD_NUMBER = 3'd4
  } cmd_e;

  localparam logic [ROW_W-1:0] ROW_FIRST  = 2'd0;
  localparam logic [ROW_W-1:0] ROW_SECOND = 2'd1;

  typedef enum logic [2:0] {
    SRC_INIT   = 3'd0,
    SRC_BYTE   = 3'd1,
    SRC_ROW    = 3'd2,
    SRC_CURSOR = 3'd3,
    SRC_DIGIT  = 3'd4
  } src_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
    src_e src;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ROW_W-1:0] row;
    logic             col_zero;
    logic             col_one;
    logic             init_last;
    logic             quot_zero;
    logic             div_done;
    logic             dig_one;
    logic             dig_zero;
    logic             slot_free;
  } dp_sts_t;

endpackage

[hw/rtl/clws_req_if.sv]
interface clws_req_if;
  logic                           valid;
  logic                           ready;
  logic [clws_pkg::CMD_W-1:0]     command;
  logic [clws_pkg::BYTE_W-1:0]    byte_value;
  logic [clws_pkg::COL_W-1:0]     column;
  logic [clws_pkg::ROW_W-1:0]     row;
  logic [clws_pkg::NUMBER_W-1:0]  number;

  modport source (
    output valid, command, byte_value, column, row, number,
    input  ready
  );

  modport sink (
    input  valid, command, byte_value, column, row, number,
    output ready
  );
endinterface

[hw/rtl/clws_wr_if.sv]
interface clws_wr_if;
  logic                         valid;
  logic                         ready;
  logic                         register_select;
  logic [clws_pkg::BYTE_W-1:0]  bus_byte;
  logic                         last;

  modport source (
    output valid, register_select, bus_byte, last,
    input  ready
  );

  modport sink (
    input  valid, register_select, bus_byte, last,
    output ready
  );
endinterface

[hw/rtl/clws_ctrl.sv]
module clws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  clws_pkg::dp_sts_t sts_i,
  output clws_pkg::dp_cmd_t cmd_o
);
  import clws_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_INIT     = 8'b0000_0100,
    S_ONE      = 8'b0000_1000,
    S_ROW      = 8'b0001_0000,
    S_COL      = 8'b0010_0000,
    S_DIV      = 8'b0100_0000,
    S_NUM      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.div_step = 1'b0;
    cmd_o.emit     = 1'b0;
    cmd_o.src      = SRC_BYTE;
    cmd_o.last     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.cmd) inside
          CMD_INIT:             state_d = S_INIT;
          CMD_INSTR, CMD_DATA:  state_d = S_ONE;
          CMD_GOTO: begin
            if (sts_i.row == ROW_SECOND) begin
              state_d = S_ROW;
            end else if (sts_i.row == ROW_FIRST && !sts_i.col_zero) begin
              state_d = S_COL;
            end else begin
              state_d = S_IDLE;
            end
          end
          CMD_NUMBER:           state_d = S_DIV;
          default:              state_d = S_IDLE;
        endcase
      end
      S_INIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_INIT;
          cmd_o.last = sts_i.init_last;
          if (sts_i.init_last) state_d = S_IDLE;
        end
      end
      S_ONE: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_BYTE;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_ROW: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_ROW;
          cmd_o.last = sts_i.col_zero;
          state_d    = sts_i.col_zero ? S_IDLE : S_COL;
        end
      end
      S_COL: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_CURSOR;
          cmd_o.last = sts_i.col_one;
          if (sts_i.col_one) state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.quot_zero || sts_i.div_done) state_d = S_NUM;
      end
      S_NUM: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_DIGIT;
          cmd_o.last = sts_i.dig_one;
          if (sts_i.dig_one) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.slot_free)
    else $error("write issued while output register is occupied");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> state_q == S_IDLE)
    else $error("run closed but sequencer did not return to idle");

  a_digits_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NUM |-> !sts_i.dig_zero)
    else $error("digit emission with empty digit store");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_DISPATCH)
    else $error("request load did not lead to dispatch");

endmodule

[hw/rtl/clws_dpath.sv]
module clws_dpath #(
  parameter int unsigned COLUMNS = clws_pkg::COLUMNS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [clws_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [clws_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic [clws_pkg::CMD_W-1:0]       command_i,
  input  logic [clws_pkg::BYTE_W-1:0]      byte_value_i,
  input  logic [clws_pkg::COL_W-1:0]       column_i,
  input  logic [clws_pkg::ROW_W-1:0]       row_i,
  input  logic [clws_pkg::NUMBER_W-1:0]    number_i,
  input  clws_pkg::dp_cmd_t                cmd_i,
  output clws_pkg::dp_sts_t                sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_rs_o,
  output logic [clws_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                             out_last_o
);
  import clws_pkg::*;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);

  logic [CFG_W-1:0]      cfg_q [NUM_REGS];
  logic [CMD_W-1:0]      cmd_q;
  logic [BYTE_W-1:0]     byte_q;
  logic [ROW_W-1:0]      row_q;
  logic [COL_W-1:0]      col_q;
  logic [NUMBER_W-1:0]   num_q;
  logic [DIGIT_W-1:0]    digit_q [NUM_DIGITS];
  logic [DIG_CNT_W-1:0]  ndig_q;
  logic [INIT_IDX_W-1:0] idx_q;
  logic                  out_valid_q;
  logic                  out_rs_q;
  logic [BYTE_W-1:0]     out_byte_q;
  logic                  out_last_q;

  logic [2*NUMBER_W-1:0] prod;
  logic [NUMBER_W-1:0]   quot;
  logic [NUMBER_W-1:0]   quot10;
  logic [NUMBER_W-1:0]   rem_full;
  logic [DIG_IDX_W-1:0]  dig_rd_idx;
  logic                  wr_rs;
  logic [BYTE_W-1:0]     wr_byte;

  // Divide by ten through the reciprocal multiply
  assign prod     = (2*NUMBER_W)'(num_q) * (2*NUMBER_W)'(DIV10_MUL);
  assign quot     = NUMBER_W'(prod >> DIV10_SHIFT);
  assign quot10   = NUMBER_W'({quot, 3'b000}) + NUMBER_W'({quot, 1'b0});
  assign rem_full = num_q - quot10;

  assign dig_rd_idx = DIG_IDX_W'(ndig_q - DIG_CNT_W'(1));

  always_comb begin
    wr_rs   = 1'b0;
    wr_byte = byte_q;
    case (cmd_i.src)
      SRC_INIT:   wr_byte = cfg_q[REG_IDX_W'(idx_q)];
      SRC_BYTE: begin
        wr_rs   = (cmd_q == CMD_DATA);
        wr_byte = byte_q;
      end
      SRC_ROW:    wr_byte = cfg_q[REG_SECOND_ROW];
      SRC_CURSOR: wr_byte = cfg_q[REG_CURSOR_RIGHT];
      SRC_DIGIT: begin
        wr_rs   = 1'b1;
        wr_byte = ASCII_ZERO + BYTE_W'(digit_q[dig_rd_idx]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= CFG_RESET[i];
    end else if (cfg_we_i && cfg_idx_i < REG_IDX_W'(NUM_REGS)) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      byte_q <= byte_value_i;
      row_q  <= row_i;
      col_q  <= (column_i > COL_MAX) ? COL_MAX : column_i;
      num_q  <= number_i;
      ndig_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.div_step) begin
        digit_q[DIG_IDX_W'(ndig_q)] <= rem_full[DIGIT_W-1:0];
        num_q                       <= quot;
        ndig_q                      <= ndig_q + DIG_CNT_W'(1);
      end
      if (cmd_i.emit) begin
        case (cmd_i.src)
          SRC_INIT:   idx_q  <= idx_q + INIT_IDX_W'(1);
          SRC_CURSOR: col_q  <= col_q - COL_W'(1);
          SRC_DIGIT:  ndig_q <= ndig_q - DIG_CNT_W'(1);
          default: ;
        endcase
      end
    end
  end

  // Output register: holds one write until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_rs_q   <= wr_rs;
      out_byte_q <= wr_byte;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rs_o    = out_rs_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  assign sts_o.cmd       = cmd_q;
  assign sts_o.row       = row_q;
  assign sts_o.col_zero  = (col_q == '0);
  assign sts_o.col_one   = (col_q == COL_W'(1));
  assign sts_o.init_last = (idx_q == INIT_IDX_W'(INIT_WRITES - 1));
  assign sts_o.quot_zero = (quot == '0);
  assign sts_o.div_done  = (ndig_q == DIG_CNT_W'(NUM_DIGITS - 1));
  assign sts_o.dig_one   = (ndig_q == DIG_CNT_W'(1));
  assign sts_o.dig_zero  = (ndig_q == '0);
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

endmodule

[hw/rtl/char_lcd_write_sequencer.sv]
// Channel   Dir   Handshake             Payload
// req_i     in    valid / ready         command, byte_value, column, row, number
// wr_o      out   valid / ready         register_select, bus_byte, last
// cfg       in    cfg_we_i (no stall)   cfg_idx_i, cfg_data_i
//
// One request at a time: a request is taken in idle, decoded in the dispatch state,
// then one bus write per cycle while the sink keeps up. Init makes four writes, send
// instruction or data one, goto one for row two plus one per column, write number
// one per decimal digit, after one reciprocal-multiply divide step per digit.
// The last write of a run is in the output register when idle is re-entered.
// rst_ni clears the state machine and the output valid and reloads the defaults.
// A stalled sink holds the current write in the output register and the sequencer.
module char_lcd_write_sequencer #(
  parameter int unsigned COLUMNS = clws_pkg::COLUMNS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [clws_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [clws_pkg::CFG_W-1:0]      cfg_data_i,
  clws_req_if.sink                        req_i,
  clws_wr_if.source                       wr_o
);
  import clws_pkg::*;

  // Command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer: decode the request and step through its writes
  clws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Datapath: setup registers, request capture, digit divider, output register
  clws_dpath #(
    .COLUMNS (COLUMNS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (req_i.command),
    .byte_value_i (req_i.byte_value),
    .column_i     (req_i.column),
    .row_i        (req_i.row),
    .number_i     (req_i.number),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .out_ready_i  (wr_o.ready),
    .out_valid_o  (wr_o.valid),
    .out_rs_o     (wr_o.register_select),
    .out_byte_o   (wr_o.bus_byte),
    .out_last_o   (wr_o.last)
  );

endmodule

[dv/tb_char_lcd_write_sequencer.sv]
`timescale 1ns / 1ps

module tb_char_lcd_write_sequencer;
  import clws_pkg::*;

  // Geometry of the instance below (default COLUMNS)
  localparam int unsigned DISPLAY_COLUMNS = 40;

  // Long receiver hold-off, settle time after the last write, quiet-cycle limit
  localparam int unsigned HOLD_OFF_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES     = 12;
  localparam int unsigned QUIET_LIMIT      = 2000;
  localparam int unsigned RANDOM_PER_PHASE = 32;
  localparam int unsigned CODE_PHASES      = 4;

  // Command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  // Rows beyond the second: goto does nothing
  localparam logic [ROW_W-1:0] ROW_THIRD  = 2'd2;
  localparam logic [ROW_W-1:0] ROW_FOURTH = 2'd3;

  // Register indexes past the end of the code file
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  localparam logic [CFG_W-1:0] CODE_DEFAULTS [NUM_REGS] = '{
    8'd56, 8'd15, 8'd1, 8'd6, 8'd20, 8'd192
  };

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [BYTE_W-1:0]   byte_value;
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row;
    logic [NUMBER_W-1:0] number;
  } lcd_req_t;

  typedef struct packed {
    logic              register_select;
    logic [BYTE_W-1:0] bus_byte;
    logic              last;
  } lcd_write_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  clws_req_if req_if ();
  clws_wr_if  wr_if ();

  char_lcd_write_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .wr_o       (wr_if)
  );

  // Shadow of the instruction code file as the block should hold it
  logic [CFG_W-1:0] code_shadow [NUM_REGS];

  // Requests waiting to be offered, and bus writes the block still owes us
  lcd_req_t   queued_requests [$];
  lcd_write_t predicted_writes [$];
  lcd_req_t   offered_req;

  int          req_gap   = 0;
  int          req_calm  = 0;
  int          wr_stall  = 0;
  int          wr_calm   = 0;
  int          hold_left = 0;
  bit          hold_off_armed = 1'b0;
  bit          hold_off_done  = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Draw an idle count for one transaction. Now and then enter a calm stretch
  // of back-to-back transactions so that full-rate behavior gets exercised too.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Expand one request into the run of bus writes it must produce, using the
  // shadow codes, and append the run to the predicted writes.
  function automatic void expand_request(lcd_req_t r);
    lcd_write_t          run [$];
    int unsigned         cols;
    logic [NUMBER_W-1:0] value;
    logic [3:0]          digits [$];
    case (r.command)
      CMD_INIT: begin
        for (int i = REG_FUNCTION_SET; i <= REG_ENTRY_MODE; i++)
          run.push_back('{RS_INSTR, code_shadow[i], 1'b0});
      end
      CMD_INSTR: run.push_back('{RS_INSTR, r.byte_value, 1'b0});
      CMD_DATA:  run.push_back('{RS_DATA, r.byte_value, 1'b0});
      CMD_GOTO: begin
        // Rows past the second are dropped; columns past the edge saturate
        if (r.row <= ROW_SECOND) begin
          cols = (r.column > DISPLAY_COLUMNS - 1) ? DISPLAY_COLUMNS - 1 : r.column;
          if (r.row == ROW_SECOND)
            run.push_back('{RS_INSTR, code_shadow[REG_SECOND_ROW], 1'b0});
          repeat (cols) run.push_back('{RS_INSTR, code_shadow[REG_CURSOR_RIGHT], 1'b0});
        end
      end
      CMD_NUMBER: begin
        // Most significant digit first, no leading zeros, zero prints one digit
        value = r.number;
        do begin
          digits.push_front(4'(value % 10));
          value = value / 10;
        end while (value != 0);
        foreach (digits[i])
          run.push_back('{RS_DATA, ASCII_ZERO + BYTE_W'(digits[i]), 1'b0});
      end
      default: ;
    endcase
    if (run.size() != 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) predicted_writes.push_back(run[i]);
  endfunction

  // Random request, weighted toward the commands that produce writes. Gotos
  // mostly use short column counts; numbers spread over every digit count.
  function automatic lcd_req_t random_request();
    lcd_req_t    r;
    int unsigned pick;
    r.byte_value = BYTE_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 8)       r.command = CMD_INIT;
    else if (pick < 24) r.command = CMD_INSTR;
    else if (pick < 42) r.command = CMD_DATA;
    else if (pick < 68) r.command = CMD_GOTO;
    else if (pick < 92) r.command = CMD_NUMBER;
    else                r.command = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
    pick = $urandom_range(0, 9);
    if (pick < 7)      r.column = COL_W'($urandom_range(0, 15));
    else if (pick < 9) r.column = COL_W'($urandom_range(16, DISPLAY_COLUMNS - 1));
    else               r.column = COL_W'($urandom_range(DISPLAY_COLUMNS, 63));
    pick = $urandom_range(0, 9);
    if (pick < 4)      r.row = ROW_FIRST;
    else if (pick < 8) r.row = ROW_SECOND;
    else               r.row = ROW_W'($urandom_range(ROW_THIRD, ROW_FOURTH));
    case ($urandom_range(0, 5))
      0:       r.number = NUMBER_W'($urandom_range(0, 9));
      1:       r.number = NUMBER_W'($urandom_range(10, 99));
      2:       r.number = NUMBER_W'($urandom_range(100, 999));
      3:       r.number = NUMBER_W'($urandom_range(1000, 9999));
      4:       r.number = NUMBER_W'($urandom_range(10000, 65535));
      default: r.number = NUMBER_W'($urandom_range(0, 65535));
    endcase
    return r;
  endfunction

  task automatic queue_request(input logic [CMD_W-1:0]    command,
                               input logic [BYTE_W-1:0]   byte_value,
                               input logic [COL_W-1:0]    column,
                               input logic [ROW_W-1:0]    row,
                               input logic [NUMBER_W-1:0] number);
    queued_requests.push_back('{command, byte_value, column, row, number});
  endtask

  // Queue random requests until the given count of real commands is reached;
  // ignored command codes ride along but do not count.
  task automatic queue_random(input int unsigned count);
    lcd_req_t    r;
    int unsigned taken = 0;
    while (taken < count) begin
      r = random_request();
      queued_requests.push_back(r);
      if (r.command <= CMD_NUMBER) taken++;
    end
  endtask

  // Write one code register; the caller drops the write enable afterwards
  task automatic write_code(input logic [REG_IDX_W-1:0] idx,
                            input logic [CFG_W-1:0]     value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx < NUM_REGS) code_shadow[idx] = value;
  endtask

  // Hold until every request went in and every predicted write came out, then
  // let the block settle so that ignored requests are surely finished.
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || req_if.valid || predicted_writes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Request driver: offer queued requests with random gaps, hold the payload
  // while the block stalls, predict the write run when a transaction completes.
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    logic offer;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_gap  = 0;
      req_calm = 0;
    end else begin
      if (req_if.valid && req_if.ready) expand_request(offered_req);
      if (!req_if.valid || req_if.ready) begin
        offer = 1'b0;
        if (req_gap > 0) begin
          req_gap--;
        end else if (queued_requests.size() != 0) begin
          offered_req = queued_requests.pop_front();
          offer       = 1'b1;
          req_gap     = draw_wait(req_calm);
          req_if.command    <= offered_req.command;
          req_if.byte_value <= offered_req.byte_value;
          req_if.column     <= offered_req.column;
          req_if.row        <= offered_req.row;
          req_if.number     <= offered_req.number;
        end
        req_if.valid <= offer;
      end
    end
  end

  // Write monitor and sink: check each completed write against the oldest
  // prediction, then decide ready for the next cycle (random stalls, plus one
  // long hold-off when armed so that the block backs up into its request side).
  always @(posedge clk_i or negedge rst_ni) begin : wr_monitor
    lcd_write_t want;
    logic       take;
    if (!rst_ni) begin
      wr_if.ready <= 1'b0;
      wr_stall      = 0;
      wr_calm       = 0;
      hold_left     = 0;
      hold_off_done = 1'b0;
    end else begin
      if (wr_if.valid && wr_if.ready) begin
        if (predicted_writes.size() == 0) begin
          $error("unexpected write: register_select %0d bus_byte 0x%02h last %0d",
                 wr_if.register_select, wr_if.bus_byte, wr_if.last);
          mismatches++;
        end else begin
          want = predicted_writes.pop_front();
          if (wr_if.register_select !== want.register_select) begin
            $error("register_select: expected %0d, got %0d",
                   want.register_select, wr_if.register_select);
            mismatches++;
          end
          if (wr_if.bus_byte !== want.bus_byte) begin
            $error("bus_byte: expected 0x%02h, got 0x%02h", want.bus_byte, wr_if.bus_byte);
            mismatches++;
          end
          if (wr_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, wr_if.last);
            mismatches++;
          end
        end
      end

      if (hold_off_armed && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold_left     = HOLD_OFF_CYCLES;
      end

      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (wr_stall > 0) begin
        wr_stall--;
        take = (wr_stall == 0);
      end else if (wr_if.valid && wr_if.ready) begin
        wr_stall = draw_wait(wr_calm);
        take     = (wr_stall == 0);
      end else begin
        take = 1'b1;
      end
      wr_if.ready <= take;
    end
  end

  // Watchdog: end the run if no transaction completes on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (wr_if.valid && wr_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] code;

    // Drive every block input to a known value from time zero
    req_if.valid      = 1'b0;
    req_if.command    = '0;
    req_if.byte_value = '0;
    req_if.column     = '0;
    req_if.row        = '0;
    req_if.number     = '0;
    wr_if.ready       = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    foreach (code_shadow[i]) code_shadow[i] = CODE_DEFAULTS[i];

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests on the reset codes: field extremes, every command,
    // goto edge cases (origin, saturation, ignored rows), zero and 65535
    queue_request(CMD_INIT,   8'h00, 6'd0,  ROW_FIRST,  16'd0);
    queue_request(CMD_INSTR,  8'h00, 6'd0,  ROW_FIRST,  16'd0);
    queue_request(CMD_INSTR,  8'hFF, 6'd63, ROW_FOURTH, 16'hFFFF);
    queue_request(CMD_DATA,   8'h00, 6'd0,  ROW_FIRST,  16'd0);
    queue_request(CMD_DATA,   8'hFF, 6'd0,  ROW_FIRST,  16'd0);
    queue_request(CMD_DATA,   8'hA5, 6'd0,  ROW_FIRST,  16'd0);
    queue_request(CMD_GOTO,   8'h00, 6'd0,  ROW_FIRST,  16'd0);
    queue_request(CMD_GOTO,   8'h00, 6'd1,  ROW_FIRST,  16'd0);
    queue_request(CMD_GOTO,   8'h00, 6'd0,  ROW_SECOND, 16'd0);
    queue_request(CMD_GOTO,   8'h00, 6'd39, ROW_SECOND, 16'd0);
    queue_request(CMD_GOTO,   8'h00, 6'd39, ROW_FIRST,  16'd0);
    queue_request(CMD_GOTO,   8'h00, 6'd40, ROW_FIRST,  16'd0);
    queue_request(CMD_GOTO,   8'hFF, 6'd63, ROW_SECOND, 16'd0);
    queue_request(CMD_GOTO,   8'h00, 6'd5,  ROW_THIRD,  16'd0);
    queue_request(CMD_GOTO,   8'h00, 6'd63, ROW_FOURTH, 16'd0);
    queue_request(CMD_NUMBER, 8'h00, 6'd0,  ROW_FIRST,  16'd0);
    queue_request(CMD_NUMBER, 8'h00, 6'd0,  ROW_FIRST,  16'd7);
    queue_request(CMD_NUMBER, 8'h00, 6'd0,  ROW_FIRST,  16'd10);
    queue_request(CMD_NUMBER, 8'h00, 6'd0,  ROW_FIRST,  16'd99);
    queue_request(CMD_NUMBER, 8'h00, 6'd0,  ROW_FIRST,  16'd10000);
    queue_request(CMD_NUMBER, 8'hFF, 6'd63, ROW_FOURTH, 16'hFFFF);
    queue_request(CMD_RSVD_FIRST, 8'hFF, 6'd63, ROW_SECOND, 16'hFFFF);
    queue_request(CMD_W'(CMD_RSVD_FIRST + 1), 8'h5A, 6'd3, ROW_FIRST, 16'd12345);
    queue_request(CMD_RSVD_LAST,  8'h00, 6'd0,  ROW_FIRST,  16'd0);
    wait_for_drain();

    // Random phases, each on its own code set: all clear, all set (with the
    // long hold-off), random codes, then back to the power-up codes
    for (int p = 0; p < CODE_PHASES; p++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        case (p)
          0:       code = '0;
          1:       code = '1;
          2:       code = CFG_W'($urandom_range(0, 255));
          default: code = CODE_DEFAULTS[i];
        endcase
        write_code(REG_IDX_W'(i), code);
      end
      // Writes past the end of the file must land nowhere
      if (p == 0) begin
        write_code(REG_SPARE_LO, '1);
        write_code(REG_SPARE_HI, '1);
      end
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
      hold_off_armed = (p == 1);
      queue_random(RANDOM_PER_PHASE);
      wait_for_drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[char_lcd_write_sequencer.f]
hw/rtl/clws_pkg.sv
hw/rtl/clws_req_if.sv
hw/rtl/clws_wr_if.sv
hw/rtl/clws_ctrl.sv
hw/rtl/clws_dpath.sv
hw/rtl/char_lcd_write_sequencer.sv
dv/tb_char_lcd_write_sequencer.sv
